### rtl/core/vertex_transform_perspective_divide_core_assert.svh
// Assertion macros for the vertex transform core.
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_CORE_ASSERT_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define VTPD_ASSERT_IMPL(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("vtpd check failed");
`define VTPD_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("vtpd check failed");
`else
`define VTPD_ASSERT_IMPL(lbl, clk, rst_n, prop)
`define VTPD_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

### rtl/core/vtpd_pkg.sv
package vtpd_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int NUM_REGS = 8;
	localparam int REG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] pos_w;
		logic        last_vertex;
	} vtx_in_t;

	typedef struct packed {
		logic [31:0] ndc_x;
		logic [31:0] ndc_y;
		logic [31:0] clip_z;
		logic [31:0] clip_w;
		logic        zero_w;
		logic        overflow;
		logic        last_out;
	} vtx_out_t;
endpackage

### rtl/core/vtpd_div.sv
// Pipelined signed divider: quo = (num << FB) / den, truncated, saturated.
// One restoring step per stage; the quotient magnitude is CW+FB bits before saturation to CW bits.
module vtpd_div #(
	parameter int CW = 32,
	parameter int FB = 16,
	parameter int TW = 8
) (
	input  logic                 clk,
	input  logic                 adv,
	input  logic signed [CW-1:0] num,
	input  logic signed [CW-1:0] den,
	input  logic [TW-1:0]        tag_in,
	output logic signed [CW-1:0] quo,
	output logic                 ovf,
	output logic [TW-1:0]        tag_out
);
	localparam int NW = CW + FB;      // dividend magnitude bits
	localparam int STEPS = NW;
	localparam int RW = CW + 1;

	logic [NW-1:0] dvd_q [STEPS+1];
	logic [RW-1:0] rem_q [STEPS+1];
	logic [CW-1:0] dmag_q [STEPS+1];
	logic          neg_q [STEPS+1];
	logic          dz_q [STEPS+1];
	logic [1:0]    nsg_q [STEPS+1];
	logic [TW-1:0] tag_q [STEPS+1];

	logic [CW-1:0] nabs, dabs;
	always_comb begin
		nabs = num[CW-1] ? CW'(-num) : CW'(num);
		dabs = den[CW-1] ? CW'(-den) : CW'(den);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dvd_q[0]  <= {nabs, {FB{1'b0}}};
			rem_q[0]  <= '0;
			dmag_q[0] <= dabs;
			neg_q[0]  <= num[CW-1] ^ den[CW-1];
			dz_q[0]   <= (den == '0);
			nsg_q[0]  <= {num[CW-1], num != '0};
			tag_q[0]  <= tag_in;
		end
	end

	for (genvar s = 0; s < STEPS; s++) begin : g_step
		logic [RW-1:0] trial;
		logic [RW:0]   diff;
		always_comb begin
			trial = {rem_q[s][RW-2:0], dvd_q[s][NW-1]};
			diff  = {1'b0, trial} - {2'b0, dmag_q[s]};
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[s+1]  <= diff[RW] ? trial : diff[RW-1:0];
				dvd_q[s+1]  <= {dvd_q[s][NW-2:0], ~diff[RW]};
				dmag_q[s+1] <= dmag_q[s];
				neg_q[s+1]  <= neg_q[s];
				dz_q[s+1]   <= dz_q[s];
				nsg_q[s+1]  <= nsg_q[s];
				tag_q[s+1]  <= tag_q[s];
			end
		end
	end

	logic [NW-1:0] qm;
	logic [CW-1:0] mx;
	always_comb begin
		qm = dvd_q[STEPS];
		mx = {1'b0, {(CW-1){1'b1}}};
		ovf = 1'b0;
		if (dz_q[STEPS]) begin
			if (!nsg_q[STEPS][0]) quo = '0;
			else if (nsg_q[STEPS][1]) quo = ~mx;
			else quo = mx;
		end else if (neg_q[STEPS]) begin
			if (qm > NW'({1'b1, {(CW-1){1'b0}}})) begin
				quo = ~mx; ovf = 1'b1;
			end else quo = CW'(-qm);
		end else begin
			if (qm > NW'(mx)) begin
				quo = mx; ovf = 1'b1;
			end else quo = CW'(qm);
		end
	end
	assign tag_out = tag_q[STEPS];
endmodule

### rtl/core/vertex_transform_perspective_divide_core.sv
// Vertex transform with perspective divide.
// Input channel in_valid/in_stall/in_data carries one vertex transaction
// (x, y, z, w, last flag). The vertex is multiplied as a row vector by a
// 4x4 Q matrix loaded through cfg_valid/cfg_ready/cfg_index/cfg_data, then
// x and y are divided by the transformed w.
// Output channel out_valid/out_stall/out_data carries one result per vertex.
// Throughput: one vertex per cycle while out_stall does not hold the
// pipeline. Pipeline registers in order: multiply stage, two adder stages,
// divider load register, one restoring-divider step per quotient bit, one
// output register.
// The whole pipeline advances as one: when out_stall is high with a valid
// result held, every stage holds and in_stall is raised; nothing is lost.
// Reset clears all valid bits and loads the identity matrix.
// The user must write configuration only while the pipeline is empty (not enforced).
`include "vertex_transform_perspective_divide_core_assert.svh"
module vertex_transform_perspective_divide_core #(
	parameter int FRAC_BITS = vtpd_pkg::FRAC_BITS_DEF,
	parameter int COORD_WIDTH = vtpd_pkg::COORD_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  vtpd_pkg::vtx_in_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output vtpd_pkg::vtx_out_t                  out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [vtpd_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [vtpd_pkg::CFG_DATA_W-1:0]     cfg_data
);
	localparam int CW = COORD_WIDTH;
	localparam int PW = 2 * CW;
	localparam int SW = PW + 2;
	localparam int LAT = CW + FRAC_BITS + 1;
	// tag: c0 divided later alongside c1; tag carries c2, c3, ovf, zero_w, last
	localparam int TW = 2 * CW + 3;
	localparam logic signed [SW-1:0] SMAX = SW'({1'b0, {(CW-1){1'b1}}});
	localparam logic signed [SW-1:0] SMIN = ~SMAX;

	logic [vtpd_pkg::CFG_DATA_W-1:0] cfg_q [vtpd_pkg::NUM_REGS];
	logic adv;

	assign cfg_ready = 1'b1;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Hold the matrix; reset to identity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[0] <= 64'(64'd1 << FRAC_BITS);
			cfg_q[1] <= '0;
			cfg_q[2] <= 64'(64'd1 << FRAC_BITS) << 32;
			cfg_q[3] <= '0;
			cfg_q[4] <= '0;
			cfg_q[5] <= 64'(64'd1 << FRAC_BITS);
			cfg_q[6] <= '0;
			cfg_q[7] <= 64'(64'd1 << FRAC_BITS) << 32;
		end else if (cfg_valid) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	function automatic logic signed [CW-1:0] ent(input logic [63:0] r, input logic hi);
		logic [31:0] h;
		h = hi ? r[63:32] : r[31:0];
		return h[CW-1:0];
	endfunction

	logic signed [CW-1:0] v [4];
	assign v[0] = in_data.pos_x[CW-1:0];
	assign v[1] = in_data.pos_y[CW-1:0];
	assign v[2] = in_data.pos_z[CW-1:0];
	assign v[3] = in_data.pos_w[CW-1:0];

	// Stage 1: sixteen products.
	logic signed [PW-1:0] prod_s1 [4][4];
	logic vld_s1, last_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 4; j++)
					prod_s1[i][j] <= PW'(v[i] * ent(cfg_q[2*i + j/2], 1'((j % 2))));
			last_s1 <= in_data.last_vertex;
		end
	end

	// Stage 2: pairwise sums.
	logic signed [SW-1:0] pair_s2 [2][4];
	logic vld_s2, last_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 4; j++) begin
				pair_s2[0][j] <= SW'(prod_s1[0][j]) + SW'(prod_s1[1][j]);
				pair_s2[1][j] <= SW'(prod_s1[2][j]) + SW'(prod_s1[3][j]);
			end
			last_s2 <= last_s1;
		end
	end

	// Stage 3: final sum, floor shift, saturate.
	logic signed [SW-1:0] tot [4];
	logic signed [CW-1:0] csat [4];
	logic [3:0] ov;
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			tot[j] = (pair_s2[0][j] + pair_s2[1][j]) >>> FRAC_BITS;
			ov[j] = 1'b0;
			csat[j] = tot[j][CW-1:0];
			if (tot[j] > SMAX) begin
				csat[j] = {1'b0, {(CW-1){1'b1}}}; ov[j] = 1'b1;
			end else if (tot[j] < SMIN) begin
				csat[j] = {1'b1, {(CW-1){1'b0}}}; ov[j] = 1'b1;
			end
		end
	end
	logic signed [CW-1:0] c_s3 [4];
	logic vld_s3, last_s3, ov_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 4; j++) c_s3[j] <= csat[j];
			ov_s3 <= |ov;
			last_s3 <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid; vld_s2 <= vld_s1; vld_s3 <= vld_s2;
		end
	end

	// Divide x and y by w in matching pipelines.
	logic [TW-1:0] tag_in, tag_out, tag_unused;
	logic signed [CW-1:0] qx, qy;
	logic ovx, ovy;
	assign tag_in = {c_s3[2], c_s3[3], ov_s3, c_s3[3] == '0, last_s3};

	vtpd_div #(.CW(CW), .FB(FRAC_BITS), .TW(TW)) u_div_x (
		.clk, .adv, .num(c_s3[0]), .den(c_s3[3]), .tag_in,
		.quo(qx), .ovf(ovx), .tag_out);
	vtpd_div #(.CW(CW), .FB(FRAC_BITS), .TW(TW)) u_div_y (
		.clk, .adv, .num(c_s3[1]), .den(c_s3[3]), .tag_in,
		.quo(qy), .ovf(ovy), .tag_out(tag_unused));

	// Advance valid alongside the divider stages.
	logic [LAT-1:0] vld_d_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_d_q <= '0;
		else if (adv) vld_d_q <= {vld_d_q[LAT-2:0], vld_s3};
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= vld_d_q[LAT-1];
	end
	logic signed [CW-1:0] oz, ow;
	assign oz = tag_out[TW-1 -: CW];
	assign ow = tag_out[CW+2 -: CW];
	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.ndc_x    <= 32'(qx);
			out_data.ndc_y    <= 32'(qy);
			out_data.clip_z   <= 32'(oz);
			out_data.clip_w   <= 32'(ow);
			out_data.overflow <= tag_out[2] | ovx | ovy;
			out_data.zero_w   <= tag_out[1];
			out_data.last_out <= tag_out[0];
		end
	end

	`VTPD_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`VTPD_ASSERT_IMPL(a_stall, clk, arst_n, in_stall == (out_valid && out_stall))
	`VTPD_ASSERT_NEXT(a_data_hold, clk, arst_n, out_valid && out_stall, $stable(out_data))
	`VTPD_ASSERT_IMPL(a_zwo, clk, arst_n, !(out_valid && out_data.zero_w && out_data.clip_w != '0))
endmodule
